// File: rtl/core/bqla_pkg.sv
// ----------------------------------------------------------------------------
// bqla_pkg: shared types, constants and the box quantizer
// Holds the Q value format, register indexes, controller commands and the
// function that maps the cart-pole measurements onto one of the boxes.
// ----------------------------------------------------------------------------
package bqla_pkg;

	// Table geometry and field widths.
	localparam int NUM_STATES = 162;
	localparam int BOX_W      = 8;
	localparam int Q_W        = 32;
	localparam int MEAS_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0]  CFG_LEARN_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0]  CFG_DISCOUNT   = 2'd1;
	localparam logic [CFG_DATA_W-1:0] LEARN_RATE_RST = 16'd32768;
	localparam logic [CFG_DATA_W-1:0] DISCOUNT_RST   = 16'd65470;

	// Quantizer limits on the raw Q3.12 codes.
	localparam logic signed [MEAS_W-1:0] POS_FAIL   = 16'sd9830;
	localparam logic signed [MEAS_W-1:0] POS_LO     = -16'sd3276;
	localparam logic signed [MEAS_W-1:0] POS_HI     = 16'sd3277;
	localparam logic signed [MEAS_W-1:0] VEL_LO     = -16'sd2048;
	localparam logic signed [MEAS_W-1:0] VEL_HI     = 16'sd2048;
	localparam logic signed [MEAS_W-1:0] ANG_FAIL   = 16'sd857;
	localparam logic signed [MEAS_W-1:0] ANG_LO2    = -16'sd428;
	localparam logic signed [MEAS_W-1:0] ANG_LO1    = -16'sd71;
	localparam logic signed [MEAS_W-1:0] ANG_HI1    = 16'sd72;
	localparam logic signed [MEAS_W-1:0] ANG_HI2    = 16'sd429;
	localparam logic signed [MEAS_W-1:0] RATE_LO    = -16'sd3574;
	localparam logic signed [MEAS_W-1:0] RATE_HI    = 16'sd3575;

	typedef logic signed [Q_W-1:0] q_t;
	typedef logic [BOX_W-1:0]      box_t;

	typedef struct packed {
		logic fail;
		box_t box;
	} quant_t;

	// Commands from the controller to the datapath, one per step.
	typedef struct packed {
		logic load;
		logic rd_next;
		logic rd_last;
		logic mul1;
		logic diff;
		logic mul2;
		logic commit;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic out_free;
	} status_t;

	// Map the four measurements onto a box, or flag a failure.
	function automatic quant_t quantize(
		input logic signed [MEAS_W-1:0] x,
		input logic signed [MEAS_W-1:0] xd,
		input logic signed [MEAS_W-1:0] th,
		input logic signed [MEAS_W-1:0] thd
	);
		quant_t res;
		box_t   b;
		b = '0;
		if (x < POS_LO) b = 8'd0;
		else if (x < POS_HI) b = 8'd1;
		else b = 8'd2;
		if (xd < VEL_LO) b = b;
		else if (xd < VEL_HI) b = b + 8'd3;
		else b = b + 8'd6;
		if (th < ANG_LO2) b = b;
		else if (th < ANG_LO1) b = b + 8'd9;
		else if (th < 16'sd0) b = b + 8'd18;
		else if (th < ANG_HI1) b = b + 8'd27;
		else if (th < ANG_HI2) b = b + 8'd36;
		else b = b + 8'd45;
		if (thd < RATE_LO) b = b;
		else if (thd < RATE_HI) b = b + 8'd54;
		else b = b + 8'd108;
		res.fail = (x < -POS_FAIL) || (x > POS_FAIL) || (th < -ANG_FAIL) || (th > ANG_FAIL);
		res.box  = b;
		return res;
	endfunction

endpackage

// File: rtl/core/bqla_ctrl.sv
// ----------------------------------------------------------------------------
// bqla_ctrl: step sequencer
// Walks each accepted word through table reads, the two multiplies and the
// write-back, and holds the commit until the result register is free.
// ----------------------------------------------------------------------------
module bqla_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  bqla_pkg::status_t status,
	output bqla_pkg::cmd_t    cmd
);
	import bqla_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDN  = 3'd1;
	localparam logic [2:0] ST_RDL  = 3'd2;
	localparam logic [2:0] ST_MUL1 = 3'd3;
	localparam logic [2:0] ST_DIFF = 3'd4;
	localparam logic [2:0] ST_MUL2 = 3'd5;
	localparam logic [2:0] ST_WR   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_RDN;
			ST_RDN:  state_d = ST_RDL;
			ST_RDL:  state_d = ST_MUL1;
			ST_MUL1: state_d = ST_DIFF;
			ST_DIFF: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_WR;
			ST_WR:   if (status.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Command decode.
	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && in_valid;
		cmd.rd_next = (state_q == ST_RDN);
		cmd.rd_last = (state_q == ST_RDL);
		cmd.mul1    = (state_q == ST_MUL1);
		cmd.diff    = (state_q == ST_DIFF);
		cmd.mul2    = (state_q == ST_MUL2);
		cmd.commit  = (state_q == ST_WR) && status.out_free;
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// File: rtl/core/bqla_datapath.sv
// ----------------------------------------------------------------------------
// bqla_datapath: quantizer, Q table and update arithmetic
// Keeps the two action columns of the Q table in memories with one valid
// flop per box, computes the update and holds the result register.
// ----------------------------------------------------------------------------
module bqla_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bqla_pkg::cmd_t                         cmd,
	output bqla_pkg::status_t                      status,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     cart_pos,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     cart_vel,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     pole_angle,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     pole_rate,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     reward,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   action,
	output logic                                   failed,
	output logic [bqla_pkg::BOX_W-1:0]             box_index,
	input  logic                                   cfg_valid,
	input  logic [bqla_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bqla_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import bqla_pkg::*;

	// Configuration registers.
	logic [CFG_DATA_W-1:0] learn_rate_q;
	logic [CFG_DATA_W-1:0] discount_q;

	// Step state.
	quant_t                    qnt;
	logic                      fail_q;
	box_t                      box_q;
	logic signed [MEAS_W-1:0]  reward_q;
	box_t                      last_box_q;
	logic                      last_action_q;
	logic                      last_valid_q;

	// Table storage.
	q_t                        mem0 [NUM_STATES];
	q_t                        mem1 [NUM_STATES];
	logic [NUM_STATES-1:0]     row_valid_q;
	box_t                      rd_addr;
	q_t                        rd0_q;
	q_t                        rd1_q;
	logic                      rdv_q;
	q_t                        rd0_m;
	q_t                        rd1_m;

	// Arithmetic registers.
	q_t                        q0n_q;
	q_t                        q1n_q;
	q_t                        maxq_q;
	q_t                        qlast_q;
	logic signed [48:0]        prod1_q;
	logic signed [34:0]        diff_q;
	logic signed [51:0]        prod2_q;
	logic signed [16:0]        disc_s;
	logic signed [16:0]        alpha_s;
	logic signed [34:0]        diff_d;
	logic signed [36:0]        nq_wide;
	q_t                        nq;
	q_t                        q0a;
	q_t                        q1a;
	logic                      act;
	logic                      wr0;
	logic                      wr1;
	q_t                        wd0;
	q_t                        wd1;

	// Result register.
	logic                      out_valid_q;
	logic                      action_q;
	logic                      failed_q;
	box_t                      box_index_q;

	// Configuration writes; indexes beyond the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q <= LEARN_RATE_RST;
			discount_q   <= DISCOUNT_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_LEARN_RATE) learn_rate_q <= cfg_data;
			if (cfg_index == CFG_DISCOUNT) discount_q <= cfg_data;
		end
	end

	// Capture the incoming word and its box.
	assign qnt = quantize(cart_pos, cart_vel, pole_angle, pole_rate);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			fail_q   <= qnt.fail;
			box_q    <= qnt.box;
			reward_q <= reward;
		end
	end

	// Table memories: registered read, write at the previous box.
	assign rd_addr = cmd.rd_last ? last_box_q : box_q;

	always_ff @(posedge clk) begin
		if (wr0) mem0[last_box_q] <= wd0;
		if (wr1) mem1[last_box_q] <= wd1;
		rd0_q <= mem0[rd_addr];
		rd1_q <= mem1[rd_addr];
		rdv_q <= row_valid_q[rd_addr];
	end

	// A box never written reads as zero.
	assign rd0_m = rdv_q ? rd0_q : '0;
	assign rd1_m = rdv_q ? rd1_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr0 || wr1) begin
			row_valid_q[last_box_q] <= 1'b1;
		end
	end

	// Next-box row and its maximum; the maximum is zero on failure.
	always_ff @(posedge clk) begin
		if (cmd.rd_last) begin
			q0n_q  <= rd0_m;
			q1n_q  <= rd1_m;
			maxq_q <= fail_q ? '0 : ((rd0_m <= rd1_m) ? rd1_m : rd0_m);
		end
	end

	// gamma times maxQ, and the Q value being updated.
	assign disc_s  = $signed({1'b0, discount_q});
	assign alpha_s = $signed({1'b0, learn_rate_q});

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			qlast_q <= last_action_q ? rd1_m : rd0_m;
			prod1_q <= disc_s * maxq_q;
		end
	end

	// Temporal difference: r + gamma*maxQ - Q, in Q18.16.
	assign diff_d = $signed({{15{reward_q[MEAS_W-1]}}, reward_q, 4'b0000})
		+ $signed({{2{prod1_q[48]}}, prod1_q[48:16]})
		- $signed({{3{qlast_q[Q_W-1]}}, qlast_q});

	always_ff @(posedge clk) begin
		if (cmd.diff) diff_q <= diff_d;
		if (cmd.mul2) prod2_q <= alpha_s * diff_q;
	end

	// New Q value with saturation to the 32-bit range.
	assign nq_wide = $signed({{5{qlast_q[Q_W-1]}}, qlast_q})
		+ $signed({prod2_q[51], prod2_q[51:16]});

	always_comb begin
		if (nq_wide[36:31] == 6'b000000 || nq_wide[36:31] == 6'b111111) begin
			nq = nq_wide[31:0];
		end else if (nq_wide[36]) begin
			nq = {1'b1, {(Q_W-1){1'b0}}};
		end else begin
			nq = {1'b0, {(Q_W-1){1'b1}}};
		end
	end

	// Write-back; an unwritten row gets zero in its other column.
	always_comb begin
		wr0 = 1'b0;
		wr1 = 1'b0;
		if (cmd.commit && last_valid_q) begin
			if (row_valid_q[last_box_q]) begin
				wr0 = !last_action_q;
				wr1 = last_action_q;
			end else begin
				wr0 = 1'b1;
				wr1 = 1'b1;
			end
		end
		wd0 = last_action_q ? '0 : nq;
		wd1 = last_action_q ? nq : '0;
	end

	// Greedy action on the updated row, ties going to action one.
	always_comb begin
		q0a = q0n_q;
		q1a = q1n_q;
		if (last_valid_q && (last_box_q == box_q)) begin
			if (last_action_q) q1a = nq;
			else q0a = nq;
		end
		act = (q0a <= q1a);
	end

	// Trial bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_box_q    <= '0;
			last_action_q <= 1'b0;
			last_valid_q  <= 1'b0;
		end else if (cmd.commit) begin
			if (fail_q) begin
				last_valid_q <= 1'b0;
			end else begin
				last_box_q    <= box_q;
				last_action_q <= act;
				last_valid_q  <= 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			action_q    <= fail_q ? 1'b0 : act;
			failed_q    <= fail_q;
			box_index_q <= fail_q ? '0 : box_q;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid       = out_valid_q;
	assign action          = action_q;
	assign failed          = failed_q;
	assign box_index       = box_index_q;

endmodule

// File: rtl/core/boxes_q_learning_agent.sv
// ----------------------------------------------------------------------------
// boxes_q_learning_agent: tabular Q-learning cart-pole controller
// Each word is taken only while idle; two table reads, the first multiply, the
// difference, the second multiply and the write-back follow in turn, and the
// result register is loaded at the write-back, which waits while it is held.
// Reset clears the per-box valid flops at once, so the table reads as zero
// with no clearing pass; the configuration registers return to their defaults.
// ----------------------------------------------------------------------------
module boxes_q_learning_agent (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     cart_pos,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     cart_vel,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     pole_angle,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     pole_rate,
	input  logic signed [bqla_pkg::MEAS_W-1:0]     reward,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   action,
	output logic                                   failed,
	output logic [bqla_pkg::BOX_W-1:0]             box_index,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [bqla_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bqla_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import bqla_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Registers are always writable.
	assign cfg_ready = 1'b1;

	bqla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	bqla_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.cart_pos   (cart_pos),
		.cart_vel   (cart_vel),
		.pole_angle (pole_angle),
		.pole_rate  (pole_rate),
		.reward     (reward),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.action     (action),
		.failed     (failed),
		.box_index  (box_index),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

endmodule
